// ===== hdl/psfe_pkg.sv =====
// Package for the packet serial frame encoder.
// Holds the queue entry type, frame constants and the CRC-14 byte update.
// No dependencies.
package psfe_pkg;

  // Operation codes on the input channel
  localparam logic OP_RAW    = 1'b0;
  localparam logic OP_NUMBER = 1'b1;

  // Result byte kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_CRC_LO  = 2'd1;
  localparam logic [1:0] KIND_CRC_HI  = 2'd2;

  // CRC-14, reflected, seven shifts per byte
  localparam logic [13:0] CRC_INIT = 14'h3fff;
  localparam logic [13:0] CRC_POLY = 14'h22f0;

  // Number packing
  localparam int unsigned NUM_W       = 30;
  localparam logic [28:0] NUM_MAXMAG  = 29'h1fffffff;
  localparam logic [2:0]  NBYTES_MAX  = 3'd5;

  // One accepted item, classified, waiting for the back end
  typedef struct packed {
    logic             op;
    logic [NUM_W-1:0] value;      // folded number, or raw byte in bits 7:0
    logic [2:0]       nbytes;     // payload bytes this item emits
    logic             frame_end;
  } psfe_entry_t;

  // Absorb the low 7 bits of one byte into the running CRC
  function automatic logic [13:0] crc_absorb(input logic [13:0] crc,
                                             input logic [6:0]  data);
    logic [13:0] c;
    c = crc ^ {7'b0, data};
    for (int k = 0; k < 7; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/psfe_front.sv =====
// Front end of the frame encoder: accepts input transactions and classifies them.
// Sign-folds and clamps numbers and counts their packed bytes.
// Depends on psfe_pkg.
module psfe_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  operation,
  input  logic [7:0]            data_byte,
  input  logic signed [29:0]    number,
  input  logic                  frame_end,
  input  logic                  queue_full,
  output logic                  push,
  output psfe_pkg::psfe_entry_t entry
);
  import psfe_pkg::*;

  logic             neg;
  logic [NUM_W-1:0] mag_full;
  logic [28:0]      mag;
  logic [NUM_W-1:0] folded;
  logic [2:0]       num_bytes;

  // Handshake: take a transaction whenever the queue has room
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Sign fold: magnitude shifted left, low bit marks negative
  assign neg      = number[NUM_W-1];
  assign mag_full = neg ? (NUM_W'(0) - NUM_W'(number)) : NUM_W'(number);
  assign mag      = mag_full[NUM_W-1] ? NUM_MAXMAG : mag_full[28:0];
  assign folded   = {mag, neg};

  // Six value bits per packed byte
  always_comb begin
    if (folded[29:24] != 6'd0)      num_bytes = NBYTES_MAX;
    else if (folded[23:18] != 6'd0) num_bytes = 3'd4;
    else if (folded[17:12] != 6'd0) num_bytes = 3'd3;
    else if (folded[11:6] != 6'd0)  num_bytes = 3'd2;
    else                            num_bytes = 3'd1;
  end

  always_comb begin
    entry.op        = operation;
    entry.frame_end = frame_end;
    if (operation == OP_NUMBER) begin
      entry.value  = folded;
      entry.nbytes = num_bytes;
    end else begin
      entry.value  = {{(NUM_W-8){1'b0}}, data_byte};
      entry.nbytes = 3'd1;
    end
  end

endmodule

// ===== hdl/psfe_queue.sv =====
// Short register queue between front and back end of the frame encoder.
// Depends on psfe_pkg.
module psfe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  psfe_pkg::psfe_entry_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output psfe_pkg::psfe_entry_t head
);
  import psfe_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  psfe_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      case ({push, pop})
        2'b10:   count <= CNT_W'(count + 1'b1);
        2'b01:   count <= CNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/psfe_back.sv =====
// Back end of the frame encoder: emits one byte per cycle unless stalled, keeps the
// running CRC-14 and appends the two CRC bytes at frame end. Depends on psfe_pkg.
module psfe_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  psfe_pkg::psfe_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic [1:0]            byte_kind,
  output logic                  last_of_run
);
  import psfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAY  = 4'b0010,
    S_CRCL = 4'b0100,
    S_CRCH = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [13:0]      crc, crc_next;
  logic [NUM_W-1:0] work, work_next;
  logic [2:0]       left, left_next;
  logic             op, op_next;
  logic             fend, fend_next;

  logic             adv;
  logic             emit;
  logic [7:0]       emit_byte;
  logic [1:0]       emit_kind;
  logic             emit_last;

  logic             src_op;
  logic [NUM_W-1:0] src_value;
  logic [2:0]       src_left;
  logic             src_fend;
  logic [7:0]       pay_byte;
  logic [13:0]      crc_out;

  // Output slot is free or being taken this cycle
  assign adv = !out_valid || !out_stall;

  // Byte source: queue head when starting an item, else the working copy
  always_comb begin
    if (state == S_IDLE) begin
      src_op    = head.op;
      src_value = head.value;
      src_left  = head.nbytes;
      src_fend  = head.frame_end;
    end else begin
      src_op    = op;
      src_value = work;
      src_left  = left;
      src_fend  = fend;
    end
  end

  assign pay_byte = (src_op == OP_RAW) ? src_value[7:0]
                  : {1'b0, (src_left > 3'd1), src_value[5:0]};
  assign crc_out  = crc ^ CRC_INIT;

  // Sequencer: payload bytes, then at frame end CRC low, then CRC high
  always_comb begin
    state_next = state;
    crc_next   = crc;
    work_next  = work;
    left_next  = left;
    op_next    = op;
    fend_next  = fend;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_byte  = pay_byte;
    emit_kind  = KIND_PAYLOAD;
    emit_last  = 1'b0;
    case (state)
      S_IDLE, S_PAY: begin
        if (adv && (state == S_PAY || head_valid)) begin
          pop       = (state == S_IDLE);
          emit      = 1'b1;
          crc_next  = crc_absorb(crc, pay_byte[6:0]);
          work_next = src_value >> 6;
          left_next = 3'(src_left - 3'd1);
          op_next   = src_op;
          fend_next = src_fend;
          if (src_left <= 3'd1) begin
            if (src_fend) begin
              state_next = S_CRCL;
            end else begin
              state_next = S_IDLE;
              emit_last  = 1'b1;
            end
          end else begin
            state_next = S_PAY;
          end
        end
      end
      S_CRCL: begin
        if (adv) begin
          emit       = 1'b1;
          emit_byte  = {1'b0, crc_out[6:0]};
          emit_kind  = KIND_CRC_LO;
          state_next = S_CRCH;
        end
      end
      S_CRCH: begin
        if (adv) begin
          emit       = 1'b1;
          emit_byte  = {1'b0, crc_out[13:7]};
          emit_kind  = KIND_CRC_HI;
          emit_last  = 1'b1;
          crc_next   = CRC_INIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      crc   <= crc_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working copy and output register
  always_ff @(posedge clk) begin
    work <= work_next;
    left <= left_next;
    op   <= op_next;
    fend <= fend_next;
    if (emit) begin
      out_byte    <= emit_byte;
      byte_kind   <= emit_kind;
      last_of_run <= emit_last;
    end
  end

`ifndef SYNTH
  // Waiting for CRC high means the CRC low byte sits in the output register
  a_crch_after_crcl: assert property (@(posedge clk) disable iff (rst)
    (state == S_CRCH) |-> (out_valid && byte_kind == KIND_CRC_LO))
    else $error("CRC high pending without CRC low in output");

  // CRC high always closes the run, CRC low never does
  a_crc_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_kind == KIND_CRC_HI) |-> last_of_run)
    else $error("CRC high byte not flagged last");

  a_crcl_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_kind == KIND_CRC_LO) |-> !last_of_run)
    else $error("CRC low byte flagged last");

  // Queue is popped only when it holds an entry
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  // Sending CRC high returns the CRC to its initial value
  a_crc_reset: assert property (@(posedge clk) disable iff (rst)
    (state == S_CRCH && adv) |=> (crc == CRC_INIT))
    else $error("CRC not reinitialized after frame end");
`endif

endmodule

// ===== hdl/packet_serial_frame_encoder_unit.sv =====
// Packet serial frame encoder, top level: input port, queue and byte sequencer.
// Depends on psfe_pkg, psfe_front, psfe_queue and psfe_back.
//
// Each input transaction is a raw frame byte or a signed number; numbers are
// sign-folded and packed six bits per byte (one to five bytes), and a
// transaction marked frame_end is followed by the CRC-14 low and high bytes.
// The output side delivers one byte per clock unless out_stall holds it; a
// transaction yields nbytes + 2*frame_end bytes: 1 for a raw byte, up to 7
// for a five-byte number that ends a frame. The byte sequencer updates the CRC
// over one byte per cycle while the output is not stalled. Inputs are taken
// every cycle while the queue (QUEUE_DEPTH entries) has room, independent of
// a stall on the output.
module packet_serial_frame_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [7:0]         data_byte,
  input  logic signed [29:0] number,
  input  logic               frame_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic [1:0]         byte_kind,
  output logic               last_of_run
);
  import psfe_pkg::*;

  psfe_entry_t entry;
  psfe_entry_t head;
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        head_valid;

  psfe_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .data_byte  (data_byte),
    .number     (number),
    .frame_end  (frame_end),
    .queue_full (queue_full),
    .push       (push),
    .entry      (entry)
  );

  psfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  psfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_kind   (byte_kind),
    .last_of_run (last_of_run)
  );

endmodule
